FILE: rtl/fca_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fca_pkg - shared types and codes for the allocation table block
// Item structs, operation / status / tag codes and the sequencer states.
// -----------------------------------------------------------------------------
package fca_pkg;

	localparam int BYTE_W     = 17;  // byte_size field
	localparam int NEED_W     = 18;  // block count, up to 2^17
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 2;
	localparam int BLK_OUT_W  = 8;
	localparam int FREE_OUT_W = 9;
	localparam int TAG_W      = 2;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_USED = 2'd2;

	// table entry tags
	localparam logic [TAG_W-1:0] TAG_FREE = 2'd0;
	localparam logic [TAG_W-1:0] TAG_LINK = 2'd1;
	localparam logic [TAG_W-1:0] TAG_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_MUL,
		ST_DIV_FIX,
		ST_DISPATCH,
		ST_ALLOC,
		ST_ALLOC_END,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_LOOK_RD,
		ST_LOOK_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [BYTE_W-1:0]    byte_size;
		logic [BLK_OUT_W-1:0] head_block;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [BLK_OUT_W-1:0]  first_block;
		logic [BLK_OUT_W-1:0]  next_block;
		logic                  at_end;
		logic [FREE_OUT_W-1:0] free_blocks;
	} out_item_t;

endpackage
`default_nettype wire

FILE: rtl/fat_chain_allocator_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fat_chain_allocator_top - block allocation table with first-fit chains
// Link table in one synchronous RAM plus a free-block counter.
//
// Usage:
//   in channel (in_valid/in_ready/in_item) carries one request item:
//   allocate a chain, free a chain, or look up one entry. out channel
//   (out_valid/out_ready/out_item) returns exactly one result item each.
//   Items are processed one at a time; in_ready is high only when idle.
//   Steps per item (from accept to out_valid):
//     unknown kind        : straight to the done state
//     lookup              : divide, dispatch, one RAM read, check, done
//     allocate, no space  : divide, dispatch, done
//     allocate            : divide, dispatch, first-fit scan to the last block
//                           taken (one entry read per cycle), end mark, done
//     free                : divide, dispatch, then for each block visited
//                           a RAM read then a write-back, then done
//   The size-to-block-count divide by BLOCK_BYTES is a reciprocal multiply
//   plus one correction step.
//   Reset: a clearing pass writes every table entry free, during which
//   in_ready stays low.
//   Stall: the result sits in an output register while the next item is
//   worked; a finished item holds in the done state until out_ready takes
//   the previous result, then returns to idle.
// -----------------------------------------------------------------------------
module fat_chain_allocator_top #(
	parameter int BLOCKS      = 256,
	parameter int BLOCK_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fca_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fca_pkg::out_item_t  out_item
);
	import fca_pkg::*;

	localparam int AW     = $clog2(BLOCKS);
	localparam int CNT_W  = $clog2(BLOCKS + 1);
	localparam int MW     = TAG_W + AW;
	localparam int BB_W   = BYTE_W;
	// floor(x / BLOCK_BYTES) = (x * DIV_M) >> DIV_SH for all 17-bit x
	localparam int DIV_SH = BYTE_W + $clog2(BLOCK_BYTES);
	localparam int M_W    = BYTE_W + 2;
	localparam longint DIV_M =
		((longint'(1) << DIV_SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);

	state_t state_q, state_d;

	// link table: {tag, successor}
	logic [MW-1:0] link_mem [BLOCKS];
	logic [MW-1:0] rd_data_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [MW-1:0] wr_data;
	logic [TAG_W-1:0] rd_tag;
	logic [AW-1:0]    rd_next;

	// captured request
	logic [KIND_W-1:0]    kind_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [BLK_OUT_W-1:0] head_q;

	// size divide
	logic [M_W-1:0]         div_m;
	logic [BB_W-1:0]        div_d;
	logic [BYTE_W+M_W-1:0]  prod_div;
	logic [BYTE_W+BB_W-1:0] chk;
	logic [BYTE_W-1:0]      q_est_q, q_fix;
	logic [NEED_W-1:0]      need_q;
	logic [CNT_W-1:0]       need_cnt_q;

	// counters and walk state
	logic [CNT_W-1:0]  free_cnt_q;
	logic [AW-1:0]     clr_q;
	logic [AW:0]       scan_q;
	logic              pend_s1;
	logic [AW-1:0]     addr_s1;
	logic [CNT_W-1:0]  got_q;
	logic [AW-1:0]     prev_q, first_q, cur_q;
	logic [NEED_W-1:0] step_q;

	// result
	logic [STAT_W-1:0]    res_status_q;
	logic [BLK_OUT_W-1:0] res_first_q, res_next_q;
	logic                 res_end_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic accept, out_load, head_ok, need_over;
	logic alloc_hit, alloc_last, scan_end, free_stop;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign rd_tag  = rd_data_q[MW-1 -: TAG_W];
	assign rd_next = rd_data_q[AW-1:0];

	assign div_m    = M_W'(DIV_M);
	assign div_d    = BB_W'(BLOCK_BYTES);
	assign prod_div = (BYTE_W+M_W)'(byte_q) * (BYTE_W+M_W)'(div_m);
	assign chk      = (BYTE_W+BB_W)'(q_est_q) * (BYTE_W+BB_W)'(div_d);
	// estimate may overshoot by one; trim it back
	assign q_fix    = (chk > (BYTE_W+BB_W)'(byte_q)) ? q_est_q - BYTE_W'(1) : q_est_q;

	assign head_ok    = 32'(head_q) < 32'(BLOCKS);
	assign need_over  = need_q > NEED_W'(free_cnt_q);
	assign scan_end   = (scan_q == (AW+1)'(BLOCKS));
	assign alloc_hit  = pend_s1 && (rd_tag == TAG_FREE) && (got_q != need_cnt_q);
	assign alloc_last = (got_q + CNT_W'(1)) == need_cnt_q;
	assign free_stop  = (rd_tag == TAG_LAST) || ((step_q + NEED_W'(1)) == need_q);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = scan_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = prev_q;
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = {TAG_FREE, AW'(0)};
				if (clr_q == AW'(BLOCKS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_item.kind == KIND_NONE) ? ST_DONE : ST_DIV_MUL;
				end
			end
			ST_DIV_MUL: state_d = ST_DIV_FIX;
			ST_DIV_FIX: state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (kind_q)
					KIND_ALLOC:  state_d = need_over ? ST_DONE : ST_ALLOC;
					KIND_FREE:   state_d = head_ok ? ST_FREE_RD : ST_DONE;
					KIND_LOOKUP: state_d = head_ok ? ST_LOOK_RD : ST_DONE;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_ALLOC: begin
				// read one entry per cycle; link the previous hit to this one
				rd_en   = !scan_end;
				rd_addr = scan_q[AW-1:0];
				if (alloc_hit && (got_q != '0)) begin
					wr_en   = 1'b1;
					wr_addr = prev_q;
					wr_data = {TAG_LINK, addr_s1};
				end
				if (alloc_hit && alloc_last) state_d = ST_ALLOC_END;
			end
			ST_ALLOC_END: begin
				wr_en   = 1'b1;
				wr_addr = prev_q;
				wr_data = {TAG_LAST, AW'(0)};
				state_d = ST_DONE;
			end
			ST_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = cur_q;
				state_d = ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				if (rd_tag != TAG_FREE) begin
					wr_en   = 1'b1;
					wr_addr = cur_q;
					wr_data = {TAG_FREE, AW'(0)};
					state_d = free_stop ? ST_DONE : ST_FREE_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_LOOK_RD: begin
				rd_en   = 1'b1;
				rd_addr = cur_q;
				state_d = ST_LOOK_CHK;
			end
			ST_LOOK_CHK: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// link table RAM, one write and one registered read port
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) link_mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= link_mem[rd_addr];
	end

	// ---------------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q  <= CNT_W'(BLOCKS);
			clr_q       <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			got_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_DISPATCH: begin
					scan_q  <= '0;
					pend_s1 <= 1'b0;
					got_q   <= '0;
					step_q  <= '0;
				end
				ST_ALLOC: begin
					pend_s1 <= rd_en;
					if (rd_en) scan_q <= scan_q + (AW+1)'(1);
					if (alloc_hit) got_q <= got_q + CNT_W'(1);
				end
				ST_ALLOC_END: free_cnt_q <= free_cnt_q - need_cnt_q;
				ST_FREE_CHK: begin
					if (rd_tag != TAG_FREE) begin
						free_cnt_q <= free_cnt_q + CNT_W'(1);
						step_q     <= step_q + NEED_W'(1);
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= in_item.kind;
			byte_q       <= in_item.byte_size;
			head_q       <= in_item.head_block;
			res_status_q <= STAT_OK;
			res_first_q  <= '0;
			res_next_q   <= '0;
			res_end_q    <= 1'b0;
		end
		case (state_q)
			ST_DIV_MUL: q_est_q <= BYTE_W'(prod_div >> DIV_SH);
			ST_DIV_FIX: need_q  <= NEED_W'(q_fix) + NEED_W'(1);
			ST_DISPATCH: begin
				need_cnt_q <= CNT_W'(need_q);
				cur_q      <= AW'(head_q);
				if ((kind_q == KIND_ALLOC) && need_over) res_status_q <= STAT_NO_SPACE;
				if (((kind_q == KIND_FREE) || (kind_q == KIND_LOOKUP)) && !head_ok) begin
					res_status_q <= STAT_NOT_USED;
				end
			end
			ST_ALLOC: begin
				addr_s1 <= scan_q[AW-1:0];
				if (alloc_hit) begin
					prev_q <= addr_s1;
					if (got_q == '0) first_q <= addr_s1;
				end
			end
			ST_ALLOC_END: res_first_q <= BLK_OUT_W'(first_q);
			ST_FREE_CHK: begin
				// a free head is an error; a free block mid-walk just ends it
				if ((rd_tag == TAG_FREE) && (step_q == '0)) begin
					res_status_q <= STAT_NOT_USED;
				end
				cur_q <= rd_next;
			end
			ST_LOOK_CHK: begin
				if (rd_tag == TAG_FREE) begin
					res_status_q <= STAT_NOT_USED;
				end else if (rd_tag == TAG_LAST) begin
					res_end_q <= 1'b1;
				end else begin
					res_next_q <= BLK_OUT_W'(rd_next);
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.status      <= res_status_q;
			out_q.first_block <= res_first_q;
			out_q.next_block  <= res_next_q;
			out_q.at_end      <= res_end_q;
			out_q.free_blocks <= FREE_OUT_W'(free_cnt_q);
		end
	end

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_free_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CNT_W'(BLOCKS))
		else $error("free block count above table size");

	a_scan_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |-> !(scan_end && !pend_s1))
		else $error("first-fit scan ran off the table before filling the request");

	a_alloc_got_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |-> (got_q < need_cnt_q))
		else $error("allocation claimed more blocks than requested");

	a_walk_ascends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FREE_CHK) && (rd_tag == TAG_LINK)) |-> (rd_next > cur_q))
		else $error("chain link does not point to a higher block");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("result not posted after done");

endmodule
`default_nettype wire
